// ----- rtl/pds_pkg.sv -----
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants of the periodic deadline scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pds_pkg;

  localparam int unsigned SlotsDefault = 8;
  localparam int unsigned TimeW        = 64;
  localparam int unsigned PeriodW      = 32;
  localparam int unsigned DelayW       = 32;
  localparam int unsigned SlotOutW     = 3;
  localparam int unsigned KindW        = 2;
  localparam int unsigned CfgIdxW      = 1;

  localparam logic [DelayW-1:0] MaxDelayReset = 32'd50000;
  localparam logic [DelayW-1:0] MinDelayReset = 32'd100;

  localparam logic [CfgIdxW-1:0] CfgMaxDelay = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMinDelay = 1'b1;

  localparam logic OpRegister = 1'b0;
  localparam logic OpService  = 1'b1;

  typedef enum logic [KindW-1:0] {
    KindRegistered = 2'd0,
    KindRefused    = 2'd1,
    KindFired      = 2'd2,
    KindSleep      = 2'd3
  } kind_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic reg_write;  // write slot entry at used count
    logic scan_init;  // start slot walk at top slot
    logic scan_dec;   // step slot walk down
    logic div_start;  // start elapsed / period
    logic div_step;   // one quotient bit
    logic adv_mul;    // form steps * period
    logic adv_write;  // write advanced deadline
    logic min_init;   // start earliest search at slot zero
    logic min_step;   // fold one slot into earliest
    logic delay_calc; // compute clamped delay
  } pds_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op;
    logic reg_ok;
    logic slot_due;
    logic scan_zero;
    logic div_done;
    logic min_last;
  } pds_sts_t;

endpackage

`default_nettype wire

// ----- rtl/pds_datapath.sv -----
// ----------------------------------------------------------------------------
// pds_datapath
// Slot table, bit-serial divider, deadline advance and delay clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_datapath
  import pds_pkg::*;
#(
  parameter int unsigned Slots = SlotsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pds_cmd_t            cmd_i,
  output pds_sts_t                 sts_o,
  input  wire logic                in_op_i,
  input  wire logic [TimeW-1:0]    in_now_i,
  input  wire logic [PeriodW-1:0]  in_period_i,
  input  wire logic [DelayW-1:0]   max_delay_i,
  input  wire logic [DelayW-1:0]   min_delay_i,
  output logic [SlotOutW-1:0]      scan_slot_o,
  output logic [SlotOutW-1:0]      reg_slot_o,
  output logic [DelayW-1:0]        delay_o
);

  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CntW = $clog2(Slots + 1);
  localparam int unsigned BitW = $clog2(TimeW);

  logic                op_q;
  logic [TimeW-1:0]    now_q;
  logic [PeriodW-1:0]  period_q;
  logic [CntW-1:0]     used_q;
  logic [IdxW-1:0]     idx_q;
  logic [PeriodW-1:0]  per_mem [Slots];
  logic [TimeW-1:0]    dl_mem  [Slots];
  logic [TimeW-1:0]    rem_q, quo_q, num_q, adv_q, earliest_q;
  logic [PeriodW-1:0]  dper_q;
  logic [BitW-1:0]     bit_q;
  logic                div_done_q;
  logic                any_q;
  logic [DelayW-1:0]   delay_q;

  logic [TimeW-1:0]    cur_dl;
  logic [PeriodW-1:0]  cur_per;
  logic                cur_used;
  logic [TimeW:0]      rem_sh;
  logic [TimeW-1:0]    steps;
  logic [TimeW-1:0]    earl, gap;
  logic [DelayW-1:0]   dly;

  assign cur_dl   = dl_mem[idx_q];
  assign cur_per  = per_mem[idx_q];
  assign cur_used = ({{(CntW-IdxW){1'b0}}, idx_q} < used_q);
  assign rem_sh   = {rem_q, num_q[TimeW-1]};
  assign steps    = quo_q + {{(TimeW-1){1'b0}}, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      div_done_q <= 1'b0;
    end else begin
      if (cmd_i.reg_write) begin
        used_q <= used_q + {{(CntW-1){1'b0}}, 1'b1};
      end
      if (cmd_i.div_start) begin
        div_done_q <= 1'b0;
      end else if (cmd_i.div_step && bit_q == '0) begin
        div_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= in_op_i;
      now_q    <= in_now_i;
      period_q <= in_period_i;
    end
    if (cmd_i.reg_write) begin
      per_mem[used_q[IdxW-1:0]] <= period_q;
      dl_mem[used_q[IdxW-1:0]]  <= now_q + {{(TimeW-PeriodW){1'b0}}, period_q};
    end
    if (cmd_i.scan_init) begin
      idx_q <= IdxW'(Slots - 1);
    end else if (cmd_i.scan_dec) begin
      idx_q <= idx_q - {{(IdxW-1){1'b0}}, 1'b1};
    end else if (cmd_i.min_init) begin
      idx_q <= '0;
    end else if (cmd_i.min_step) begin
      idx_q <= idx_q + {{(IdxW-1){1'b0}}, 1'b1};
    end
    if (cmd_i.div_start) begin
      num_q  <= now_q - cur_dl;
      dper_q <= cur_per;
      rem_q  <= '0;
      quo_q  <= '0;
      bit_q  <= BitW'(TimeW - 1);
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[TimeW-2:0], 1'b0};
      bit_q <= bit_q - {{(BitW-1){1'b0}}, 1'b1};
      if (rem_sh >= {{(TimeW+1-PeriodW){1'b0}}, dper_q}) begin
        rem_q <= TimeW'(rem_sh - {{(TimeW+1-PeriodW){1'b0}}, dper_q});
        quo_q <= {quo_q[TimeW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[TimeW-1:0];
        quo_q <= {quo_q[TimeW-2:0], 1'b0};
      end
    end
    if (cmd_i.adv_mul) begin
      adv_q <= steps[31:0] * dper_q + {steps[63:32] * dper_q, 32'd0};
    end
    if (cmd_i.adv_write) begin
      dl_mem[idx_q] <= cur_dl + adv_q;
    end
    if (cmd_i.min_init) begin
      any_q <= 1'b0;
    end else if (cmd_i.min_step && cur_used) begin
      if (!any_q || cur_dl < earliest_q) begin
        earliest_q <= cur_dl;
      end
      any_q <= 1'b1;
    end
    if (cmd_i.delay_calc) begin
      delay_q <= dly;
    end
  end

  always_comb begin
    earl = (earliest_q < now_q) ? now_q : earliest_q;
    gap  = earl - now_q;
    dly  = max_delay_i;
    if (any_q && gap < {{(TimeW-DelayW){1'b0}}, max_delay_i}) begin
      dly = gap[DelayW-1:0];
    end
    if (dly < min_delay_i) begin
      dly = min_delay_i;
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.reg_ok    = (used_q < CntW'(Slots)) && (period_q != '0);
  assign sts_o.slot_due  = cur_used && (now_q >= cur_dl);
  assign sts_o.scan_zero = (idx_q == '0);
  assign sts_o.div_done  = div_done_q;
  assign sts_o.min_last  = (idx_q == IdxW'(Slots - 1));

  assign scan_slot_o = SlotOutW'(idx_q);
  assign reg_slot_o  = SlotOutW'(used_q);
  assign delay_o     = delay_q;

endmodule

`default_nettype wire

// ----- rtl/pds_ctrl.sv -----
// ----------------------------------------------------------------------------
// pds_ctrl
// Sequencer of register and service passes, with the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_ctrl
  import pds_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [KindW-1:0]         out_kind_o,
  output logic [SlotOutW-1:0]      out_slot_o,
  output logic [DelayW-1:0]        out_delay_o,
  output logic                     out_last_o,
  output pds_cmd_t                 cmd_o,
  input  wire pds_sts_t            sts_i,
  input  wire logic [SlotOutW-1:0] scan_slot_i,
  input  wire logic [SlotOutW-1:0] reg_slot_i,
  input  wire logic [DelayW-1:0]   delay_i
);

  typedef enum logic [9:0] {
    StIdle  = 10'b00_0000_0001,
    StDec   = 10'b00_0000_0010,
    StScan  = 10'b00_0000_0100,
    StDiv   = 10'b00_0000_1000,
    StMul   = 10'b00_0001_0000,
    StAdv   = 10'b00_0010_0000,
    StFire  = 10'b00_0100_0000,
    StMin   = 10'b00_1000_0000,
    StDelay = 10'b01_0000_0000,
    StEmit  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic              ov_q, ov_d;
  logic [KindW-1:0]  kind_q, kind_d;
  logic [SlotOutW-1:0] slot_q, slot_d;
  logic [DelayW-1:0] delay_q, delay_d;
  logic              last_q, last_d;
  logic              free;

  assign free = !ov_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q && !out_ready_i;
    kind_d  = kind_q;
    slot_d  = slot_q;
    delay_d = delay_q;
    last_d  = last_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDec;
        end
      end
      StDec: begin
        if (sts_i.op == OpService) begin
          cmd_o.scan_init = 1'b1;
          state_d = StScan;
        end else if (free) begin
          ov_d    = 1'b1;
          slot_d  = sts_i.reg_ok ? reg_slot_i : '0;
          kind_d  = sts_i.reg_ok ? KindRegistered : KindRefused;
          delay_d = '0;
          last_d  = 1'b1;
          cmd_o.reg_write = sts_i.reg_ok;
          state_d = StIdle;
        end
      end
      StScan: begin
        if (sts_i.slot_due) begin
          cmd_o.div_start = 1'b1;
          state_d = StDiv;
        end else if (sts_i.scan_zero) begin
          cmd_o.min_init = 1'b1;
          state_d = StMin;
        end else begin
          cmd_o.scan_dec = 1'b1;
        end
      end
      StDiv: begin
        if (sts_i.div_done) begin
          state_d = StMul;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StMul: begin
        cmd_o.adv_mul = 1'b1;
        state_d = StAdv;
      end
      StAdv: begin
        cmd_o.adv_write = 1'b1;
        state_d = StFire;
      end
      StFire: begin
        if (free) begin
          ov_d    = 1'b1;
          kind_d  = KindFired;
          slot_d  = scan_slot_i;
          delay_d = '0;
          last_d  = 1'b0;
          if (sts_i.scan_zero) begin
            cmd_o.min_init = 1'b1;
            state_d = StMin;
          end else begin
            cmd_o.scan_dec = 1'b1;
            state_d = StScan;
          end
        end
      end
      StMin: begin
        cmd_o.min_step = 1'b1;
        if (sts_i.min_last) begin
          state_d = StDelay;
        end
      end
      StDelay: begin
        cmd_o.delay_calc = 1'b1;
        state_d = StEmit;
      end
      StEmit: begin
        if (free) begin
          ov_d    = 1'b1;
          kind_d  = KindSleep;
          slot_d  = '0;
          delay_d = delay_i;
          last_d  = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    slot_q  <= slot_d;
    delay_q <= delay_d;
    last_q  <= last_d;
  end

  assign out_valid_o = ov_q;
  assign out_kind_o  = kind_q;
  assign out_slot_o  = slot_q;
  assign out_delay_o = delay_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

// ----- rtl/periodic_deadline_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// periodic_deadline_scheduler_unit
// Periodic timer table with register and service passes.
// Register pass: the beat is loaded, then the result beat is registered once
// the output is free. Service pass: slots are walked down; each due slot is
// advanced by the 64-step bit-serial divider and fired, then a sleep beat.
// One beat in flight at a time. Reset clears slot count, state and output
// valid; delay registers reset to 50000 and 100.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_deadline_scheduler_unit
  import pds_pkg::*;
#(
  parameter int unsigned Slots = SlotsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [103:0]  s_axis_tdata,  // now[63:0], period[95:64]
  input  wire logic          s_axis_tuser,  // op
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [39:0]        m_axis_tdata,  // slot[2:0], delay[34:3]
  output logic [1:0]         m_axis_tuser,  // kind
  output logic               m_axis_tlast,
  input  wire logic          cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [DelayW-1:0]  cfg_data_i
);

  pds_cmd_t            cmd;
  pds_sts_t            sts;
  logic [DelayW-1:0]   max_q, min_q, dly;
  logic [SlotOutW-1:0] scan_slot, reg_slot, oslot;
  logic [DelayW-1:0]   odly;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxDelayReset;
      min_q <= MinDelayReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMaxDelay: max_q <= cfg_data_i;
        CfgMinDelay: min_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pds_datapath #(.Slots(Slots)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .in_op_i(s_axis_tuser), .in_now_i(s_axis_tdata[63:0]),
    .in_period_i(s_axis_tdata[95:64]),
    .max_delay_i(max_q), .min_delay_i(min_q),
    .scan_slot_o(scan_slot), .reg_slot_o(reg_slot), .delay_o(dly)
  );

  pds_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_kind_o(m_axis_tuser), .out_slot_o(oslot), .out_delay_o(odly),
    .out_last_o(m_axis_tlast), .cmd_o(cmd), .sts_i(sts),
    .scan_slot_i(scan_slot), .reg_slot_i(reg_slot), .delay_i(dly)
  );

  assign m_axis_tdata = {5'd0, odly, oslot};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");
  a_sleep_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KindSleep |-> m_axis_tlast)
    else $error("sleep beat without last");

endmodule

`default_nettype wire
